// File: design/asi_pkg.sv
// ----------------------------------------------------------------------------
// asi_pkg: shared types and constants of the arc segment interpolator
// Datapath command and status structures, status codes, fixed-point constants
// and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package asi_pkg;

    // Item kinds on the input tuser
    localparam logic OPC_START = 1'b0;
    localparam logic OPC_STEP  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BUSY   = 2'd1;
    localparam logic [1:0] STATUS_SHORT  = 2'd2;
    localparam logic [1:0] STATUS_NO_ARC = 2'd3;

    // Configuration register indexes
    localparam logic REG_MIN_SEG_LEN = 1'b0;
    localparam logic REG_SEG_PERIOD  = 1'b1;

    // Angles in Q4.28, CORDIC vectors in Q2.30, all held in 34 bits
    localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
    localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
    localparam logic signed [33:0] Q28_TWO_PI  = 34'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Divider word widths
    localparam int DVD_W = 40;
    localparam int DVS_W = 32;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_REJECT,
        OP_MUL_ARC,
        OP_SCALE,
        OP_SQ_A,
        OP_SQ_B,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_LEN,
        OP_DIV_NT,
        OP_DIV_NL,
        OP_DIV_STEP,
        OP_COUNT,
        OP_DIV_ANG,
        OP_DIV_LIN,
        OP_DIV_TIME,
        OP_LOAD_ANGLE,
        OP_STEP_SUM,
        OP_WRAP,
        OP_CORDIC_INIT,
        OP_CORDIC_STEP,
        OP_MUL_SIN,
        OP_MUL_COS,
        OP_FIN_START,
        OP_FIN_STEP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic running;
        logic sqrt_last;
        logic div_last;
        logic cordic_last;
        logic too_short;
        logic wrap_ok;
    } stat_t;

    // atan(2^-i) in Q4.28
    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] v;
        begin
            unique case (i)
                5'd0:    v = 34'sd210828714;
                5'd1:    v = 34'sd124459457;
                5'd2:    v = 34'sd65760959;
                5'd3:    v = 34'sd33381290;
                5'd4:    v = 34'sd16755422;
                5'd5:    v = 34'sd8385879;
                5'd6:    v = 34'sd4193963;
                5'd7:    v = 34'sd2097109;
                5'd8:    v = 34'sd1048571;
                5'd9:    v = 34'sd524287;
                5'd10:   v = 34'sd262144;
                5'd11:   v = 34'sd131072;
                5'd12:   v = 34'sd65536;
                5'd13:   v = 34'sd32768;
                5'd14:   v = 34'sd16384;
                5'd15:   v = 34'sd8192;
                5'd16:   v = 34'sd4096;
                5'd17:   v = 34'sd2048;
                5'd18:   v = 34'sd1024;
                5'd19:   v = 34'sd512;
                5'd20:   v = 34'sd256;
                5'd21:   v = 34'sd128;
                5'd22:   v = 34'sd64;
                5'd23:   v = 34'sd32;
                5'd24:   v = 34'sd16;
                5'd25:   v = 34'sd8;
                5'd26:   v = 34'sd4;
                5'd27:   v = 34'sd2;
                5'd28:   v = 34'sd1;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: design/asi_dpath.sv
// ----------------------------------------------------------------------------
// asi_dpath: arc interpolator datapath
// Configuration and arc state registers, one shared multiplier, an iterative
// square root, a restoring divider, an iterative CORDIC and the result
// register. Every operation is chosen by the controller's command.
// ----------------------------------------------------------------------------
module asi_dpath #(
    parameter int COUNT_WIDTH  = 24,
    parameter int CORDIC_STEPS = 28
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [255:0]        s_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [30:0]         cfg_data,
    input  asi_pkg::cmd_t       cmd,
    output asi_pkg::stat_t      st,
    output logic [127:0]        m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);

    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [asi_pkg::DVD_W-1:0] CMAX =
        (asi_pkg::DVD_W'(1) << COUNT_WIDTH) - asi_pkg::DVD_W'(1);

    // Configuration
    logic [30:0] min_len_reg;
    logic [19:0] period_reg;

    // Captured start fields
    logic [31:0] sf_reg, ss_reg, sl_reg, sa_reg, trav_reg, ax_reg, dur_reg;
    logic [30:0] rad_reg;

    // Arc state
    logic                   running_reg;
    logic [31:0]            angle_now_reg, centre_first_reg, centre_second_reg;
    logic [31:0]            linear_now_reg, angle_step_reg, linear_step_reg;
    logic [31:0]            time_step_reg;
    logic [30:0]            radius_reg;
    logic [COUNT_WIDTH-1:0] seg_left_reg;

    // Work registers
    logic signed [67:0]          prod_reg;
    logic [30:0]                 arc_s_reg, lin_s_reg;
    logic [1:0]                  sh_reg;
    logic [62:0]                 sq_a_reg;
    logic [63:0]                 sq_src_reg;
    logic [33:0]                 sq_rem_reg;
    logic [31:0]                 root_reg;
    logic [35:0]                 len_reg;
    logic [asi_pkg::DVD_W-1:0]   dvd_reg, nt_reg;
    logic [asi_pkg::DVS_W-1:0]   dvs_reg, rem_reg;
    logic [COUNT_WIDTH-1:0]      n_reg;
    logic [5:0]                  cnt_reg;
    logic signed [33:0]          x_reg, y_reg, z_reg;
    logic                        neg_reg;
    logic [31:0]                 off_s_reg;

    // Result register
    logic [1:0]  res_status_reg;
    logic [31:0] res_first_reg, res_second_reg, res_linear_reg, res_dur_reg;
    logic        res_valid_reg, res_last_reg;

    // Field views
    logic        trav_neg, ax_neg;
    logic [31:0] trav_abs, ax_abs;
    logic [19:0] per_eff;
    logic [30:0] mn_eff;

    assign trav_neg = trav_reg[31];
    assign ax_neg   = ax_reg[31];
    assign trav_abs = trav_neg ? (32'd0 - trav_reg) : trav_reg;
    assign ax_abs   = ax_neg ? (32'd0 - ax_reg) : ax_reg;
    assign per_eff  = (period_reg == 20'd0) ? 20'd1 : period_reg;
    assign mn_eff   = (min_len_reg == 31'd0) ? 31'd1 : min_len_reg;

    // Sine and cosine after the half-turn fold is undone
    logic signed [33:0] sin_val, cos_val;
    assign sin_val = neg_reg ? -y_reg : y_reg;
    assign cos_val = neg_reg ? -x_reg : x_reg;

    // Shared multiplier operands
    logic signed [33:0] mul_a, mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            asi_pkg::OP_MUL_ARC:
            begin
                mul_a = {2'b00, trav_abs};
                mul_b = {3'b000, rad_reg};
            end
            asi_pkg::OP_SQ_A:
            begin
                mul_a = {3'b000, arc_s_reg};
                mul_b = {3'b000, arc_s_reg};
            end
            asi_pkg::OP_SQ_B:
            begin
                mul_a = {3'b000, lin_s_reg};
                mul_b = {3'b000, lin_s_reg};
            end
            asi_pkg::OP_MUL_SIN:
            begin
                mul_a = sin_val;
                mul_b = {3'b000, radius_reg};
            end
            asi_pkg::OP_MUL_COS:
            begin
                mul_a = cos_val;
                mul_b = {3'b000, radius_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Scale arc and axial terms so that both fit 31 bits
    logic [33:0] arc_full;
    logic [1:0]  sh_sel;
    assign arc_full = prod_reg[61:28];
    always_comb
    begin
        sh_sel = 2'd3;
        for (int s = 3; s >= 0; s--)
        begin
            if (((arc_full >> s) < 34'h80000000) && ((ax_abs >> s) < 32'h80000000))
                sh_sel = 2'(s);
        end
    end

    // Square root step: two radicand bits per cycle
    logic [35:0] sq_r2, sq_trial;
    assign sq_r2    = {sq_rem_reg, sq_src_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    // Divider step: one quotient bit per cycle
    logic [asi_pkg::DVS_W:0] dv_r2;
    logic                    dv_ge;
    assign dv_r2 = {rem_reg, dvd_reg[asi_pkg::DVD_W-1]};
    assign dv_ge = dv_r2 >= {1'b0, dvs_reg};

    // Segment count clamp
    logic [asi_pkg::DVD_W-1:0] n_min;
    logic [COUNT_WIDTH-1:0]    n_clamped;
    always_comb
    begin
        n_min = (nt_reg < dvd_reg) ? nt_reg : dvd_reg;
        if (n_min == '0)
            n_clamped = COUNT_WIDTH'(1);
        else if (n_min > CMAX)
            n_clamped = CMAX[COUNT_WIDTH-1:0];
        else
            n_clamped = n_min[COUNT_WIDTH-1:0];
    end

    // CORDIC rotation
    logic [4:0]         c_idx;
    logic signed [33:0] x_sh, y_sh, at_val;
    assign c_idx  = cnt_reg[4:0];
    assign x_sh   = x_reg >>> c_idx;
    assign y_sh   = y_reg >>> c_idx;
    assign at_val = asi_pkg::atan_entry(c_idx);

    // Segment counter after this step
    logic [COUNT_WIDTH-1:0] seg_dec;
    assign seg_dec = seg_left_reg - COUNT_WIDTH'(1);

    // Status to the controller
    assign st.running     = running_reg;
    assign st.sqrt_last   = cnt_reg == 6'd31;
    assign st.div_last    = cnt_reg == 6'(asi_pkg::DVD_W - 1);
    assign st.cordic_last = cnt_reg == 6'(STEPS - 1);
    assign st.too_short   = len_reg < {5'b0, min_len_reg};
    assign st.wrap_ok     = (z_reg >= -asi_pkg::Q28_PI) && (z_reg < asi_pkg::Q28_PI);

    // Configuration and arc state (reset clears the arc state and loads the configuration defaults)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg       <= 31'd6554;
            period_reg        <= 20'd10000;
            running_reg       <= 1'b0;
            angle_now_reg     <= '0;
            centre_first_reg  <= '0;
            centre_second_reg <= '0;
            linear_now_reg    <= '0;
            radius_reg        <= '0;
            angle_step_reg    <= '0;
            linear_step_reg   <= '0;
            time_step_reg     <= '0;
            seg_left_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == asi_pkg::REG_MIN_SEG_LEN)
                    min_len_reg <= cfg_data;
                else
                    period_reg <= cfg_data[19:0];
            end
            unique case (cmd.op)
                asi_pkg::OP_DIV_NT:      radius_reg <= rad_reg;
                asi_pkg::OP_DIV_LIN:     angle_step_reg <=
                    trav_neg ? (32'd0 - dvd_reg[31:0]) : dvd_reg[31:0];
                asi_pkg::OP_DIV_TIME:    linear_step_reg <=
                    ax_neg ? (32'd0 - dvd_reg[31:0]) : dvd_reg[31:0];
                asi_pkg::OP_LOAD_ANGLE:  time_step_reg <= dvd_reg[31:0];
                asi_pkg::OP_STEP_SUM:    linear_now_reg <= linear_now_reg + linear_step_reg;
                asi_pkg::OP_CORDIC_INIT: angle_now_reg <= z_reg[31:0];
                asi_pkg::OP_FIN_START:
                begin
                    centre_first_reg  <= sf_reg - off_s_reg;
                    centre_second_reg <= ss_reg - prod_reg[61:30];
                    linear_now_reg    <= sl_reg;
                    seg_left_reg      <= n_reg;
                    running_reg       <= 1'b1;
                end
                asi_pkg::OP_FIN_STEP:
                begin
                    seg_left_reg <= seg_dec;
                    if (seg_dec == '0)
                        running_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Work and result registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            asi_pkg::OP_CAPTURE:
            begin
                sf_reg   <= s_tdata[31:0];
                ss_reg   <= s_tdata[63:32];
                sl_reg   <= s_tdata[95:64];
                sa_reg   <= s_tdata[127:96];
                rad_reg  <= s_tdata[158:128];
                trav_reg <= s_tdata[190:159];
                ax_reg   <= s_tdata[222:191];
                dur_reg  <= s_tdata[254:223];
            end
            asi_pkg::OP_REJECT:
            begin
                res_status_reg <= cmd.status;
                res_first_reg  <= '0;
                res_second_reg <= '0;
                res_linear_reg <= '0;
                res_dur_reg    <= '0;
                res_valid_reg  <= 1'b0;
                res_last_reg   <= 1'b0;
            end
            asi_pkg::OP_MUL_ARC, asi_pkg::OP_SQ_A, asi_pkg::OP_MUL_SIN:
                prod_reg <= mul_a * mul_b;
            asi_pkg::OP_SCALE:
            begin
                sh_reg    <= sh_sel;
                arc_s_reg <= 31'(arc_full >> sh_sel);
                lin_s_reg <= 31'(ax_abs >> sh_sel);
            end
            asi_pkg::OP_SQ_B:
            begin
                sq_a_reg <= prod_reg[62:0];
                prod_reg <= mul_a * mul_b;
            end
            asi_pkg::OP_SQRT_INIT:
            begin
                sq_src_reg <= {1'b0, sq_a_reg + prod_reg[62:0]};
                sq_rem_reg <= '0;
                root_reg   <= '0;
                cnt_reg    <= '0;
            end
            asi_pkg::OP_SQRT_STEP:
            begin
                sq_src_reg <= {sq_src_reg[61:0], 2'b00};
                if (sq_r2 >= sq_trial)
                begin
                    sq_rem_reg <= 34'(sq_r2 - sq_trial);
                    root_reg   <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= sq_r2[33:0];
                    root_reg   <= {root_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            asi_pkg::OP_LEN:
                len_reg <= {4'b0, root_reg} << sh_reg;
            asi_pkg::OP_DIV_NT:
            begin
                dvd_reg <= asi_pkg::DVD_W'(dur_reg) + asi_pkg::DVD_W'(per_eff)
                           - asi_pkg::DVD_W'(1);
                dvs_reg <= asi_pkg::DVS_W'(per_eff);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            asi_pkg::OP_DIV_NL:
            begin
                nt_reg  <= dvd_reg;
                dvd_reg <= asi_pkg::DVD_W'(len_reg) + asi_pkg::DVD_W'(mn_eff)
                           - asi_pkg::DVD_W'(1);
                dvs_reg <= asi_pkg::DVS_W'(mn_eff);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            asi_pkg::OP_DIV_STEP:
            begin
                if (dv_ge)
                begin
                    rem_reg <= asi_pkg::DVS_W'(dv_r2 - {1'b0, dvs_reg});
                    dvd_reg <= {dvd_reg[asi_pkg::DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= dv_r2[asi_pkg::DVS_W-1:0];
                    dvd_reg <= {dvd_reg[asi_pkg::DVD_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            asi_pkg::OP_COUNT:
                n_reg <= n_clamped;
            asi_pkg::OP_DIV_ANG:
            begin
                dvd_reg <= asi_pkg::DVD_W'(trav_abs);
                dvs_reg <= asi_pkg::DVS_W'(n_reg);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            asi_pkg::OP_DIV_LIN:
            begin
                dvd_reg <= asi_pkg::DVD_W'(ax_abs);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            asi_pkg::OP_DIV_TIME:
            begin
                dvd_reg <= asi_pkg::DVD_W'(dur_reg);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            asi_pkg::OP_LOAD_ANGLE:
                z_reg <= {{2{sa_reg[31]}}, sa_reg};
            asi_pkg::OP_STEP_SUM:
                z_reg <= {{2{angle_now_reg[31]}}, angle_now_reg}
                       + {{2{angle_step_reg[31]}}, angle_step_reg};
            asi_pkg::OP_WRAP:
            begin
                // one turn per cycle until the angle sits in [-pi, pi)
                if (z_reg >= asi_pkg::Q28_PI)
                    z_reg <= z_reg - asi_pkg::Q28_TWO_PI;
                else if (z_reg < -asi_pkg::Q28_PI)
                    z_reg <= z_reg + asi_pkg::Q28_TWO_PI;
            end
            asi_pkg::OP_CORDIC_INIT:
            begin
                x_reg   <= asi_pkg::CORDIC_GAIN;
                y_reg   <= '0;
                cnt_reg <= '0;
                if (z_reg > asi_pkg::Q28_HALF_PI)
                begin
                    z_reg   <= z_reg - asi_pkg::Q28_PI;
                    neg_reg <= 1'b1;
                end
                else if (z_reg < -asi_pkg::Q28_HALF_PI)
                begin
                    z_reg   <= z_reg + asi_pkg::Q28_PI;
                    neg_reg <= 1'b1;
                end
                else
                    neg_reg <= 1'b0;
            end
            asi_pkg::OP_CORDIC_STEP:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - at_val;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + at_val;
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            asi_pkg::OP_MUL_COS:
            begin
                off_s_reg <= prod_reg[61:30];
                prod_reg  <= mul_a * mul_b;
            end
            asi_pkg::OP_FIN_START:
            begin
                res_status_reg <= asi_pkg::STATUS_OK;
                res_first_reg  <= '0;
                res_second_reg <= '0;
                res_linear_reg <= '0;
                res_dur_reg    <= '0;
                res_valid_reg  <= 1'b0;
                res_last_reg   <= 1'b0;
            end
            asi_pkg::OP_FIN_STEP:
            begin
                res_status_reg <= asi_pkg::STATUS_OK;
                res_first_reg  <= centre_first_reg + off_s_reg;
                res_second_reg <= centre_second_reg + prod_reg[61:30];
                res_linear_reg <= linear_now_reg;
                res_dur_reg    <= time_step_reg;
                res_valid_reg  <= 1'b1;
                res_last_reg   <= seg_dec == '0;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tdata = {res_dur_reg, res_linear_reg, res_second_reg, res_first_reg};
    assign m_tuser = {res_valid_reg, res_status_reg};
    assign m_tlast = res_last_reg;

endmodule

// File: design/asi_ctrl.sv
// ----------------------------------------------------------------------------
// asi_ctrl: arc interpolator controller
// Sequences the datapath through the start and step computations and owns
// the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
module asi_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_opcode,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  asi_pkg::stat_t st,
    output asi_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_REJECT, S_ARC_MUL, S_SCALE, S_SQ_A, S_SQ_B, S_SQRT_INIT,
        S_SQRT, S_LEN, S_CHECK, S_NT, S_NT_RUN, S_NL, S_NL_RUN, S_COUNT,
        S_ANG, S_ANG_RUN, S_LIN, S_LIN_RUN, S_TIM, S_TIM_RUN, S_LOAD_ANGLE,
        S_STEP_SUM, S_WRAP, S_CORDIC_INIT, S_CORDIC, S_MUL_SIN, S_MUL_COS,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       is_start_reg, is_start_next;
    logic [1:0] rej_code_reg, rej_code_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;

    // Next state and datapath command
    always_comb
    begin
        state_next    = state_reg;
        is_start_next = is_start_reg;
        rej_code_next = rej_code_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.op        = asi_pkg::OP_NONE;
        cmd.status    = rej_code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op        = asi_pkg::OP_CAPTURE;
                    is_start_next = s_opcode == asi_pkg::OPC_START;
                    if (s_opcode == asi_pkg::OPC_START)
                    begin
                        if (st.running)
                        begin
                            rej_code_next = asi_pkg::STATUS_BUSY;
                            state_next    = S_REJECT;
                        end
                        else
                            state_next = S_ARC_MUL;
                    end
                    else
                    begin
                        if (st.running)
                            state_next = S_STEP_SUM;
                        else
                        begin
                            rej_code_next = asi_pkg::STATUS_NO_ARC;
                            state_next    = S_REJECT;
                        end
                    end
                end
            end
            S_REJECT:
            begin
                if (out_free)
                begin
                    cmd.op        = asi_pkg::OP_REJECT;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ARC_MUL:
            begin
                cmd.op     = asi_pkg::OP_MUL_ARC;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op     = asi_pkg::OP_SCALE;
                state_next = S_SQ_A;
            end
            S_SQ_A:
            begin
                cmd.op     = asi_pkg::OP_SQ_A;
                state_next = S_SQ_B;
            end
            S_SQ_B:
            begin
                cmd.op     = asi_pkg::OP_SQ_B;
                state_next = S_SQRT_INIT;
            end
            S_SQRT_INIT:
            begin
                cmd.op     = asi_pkg::OP_SQRT_INIT;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = asi_pkg::OP_SQRT_STEP;
                if (st.sqrt_last)
                    state_next = S_LEN;
            end
            S_LEN:
            begin
                cmd.op     = asi_pkg::OP_LEN;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (st.too_short)
                begin
                    rej_code_next = asi_pkg::STATUS_SHORT;
                    state_next    = S_REJECT;
                end
                else
                    state_next = S_NT;
            end
            S_NT:
            begin
                cmd.op     = asi_pkg::OP_DIV_NT;
                state_next = S_NT_RUN;
            end
            S_NT_RUN:
            begin
                cmd.op = asi_pkg::OP_DIV_STEP;
                if (st.div_last)
                    state_next = S_NL;
            end
            S_NL:
            begin
                cmd.op     = asi_pkg::OP_DIV_NL;
                state_next = S_NL_RUN;
            end
            S_NL_RUN:
            begin
                cmd.op = asi_pkg::OP_DIV_STEP;
                if (st.div_last)
                    state_next = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.op     = asi_pkg::OP_COUNT;
                state_next = S_ANG;
            end
            S_ANG:
            begin
                cmd.op     = asi_pkg::OP_DIV_ANG;
                state_next = S_ANG_RUN;
            end
            S_ANG_RUN:
            begin
                cmd.op = asi_pkg::OP_DIV_STEP;
                if (st.div_last)
                    state_next = S_LIN;
            end
            S_LIN:
            begin
                cmd.op     = asi_pkg::OP_DIV_LIN;
                state_next = S_LIN_RUN;
            end
            S_LIN_RUN:
            begin
                cmd.op = asi_pkg::OP_DIV_STEP;
                if (st.div_last)
                    state_next = S_TIM;
            end
            S_TIM:
            begin
                cmd.op     = asi_pkg::OP_DIV_TIME;
                state_next = S_TIM_RUN;
            end
            S_TIM_RUN:
            begin
                cmd.op = asi_pkg::OP_DIV_STEP;
                if (st.div_last)
                    state_next = S_LOAD_ANGLE;
            end
            S_LOAD_ANGLE:
            begin
                cmd.op     = asi_pkg::OP_LOAD_ANGLE;
                state_next = S_WRAP;
            end
            S_STEP_SUM:
            begin
                cmd.op     = asi_pkg::OP_STEP_SUM;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                cmd.op = asi_pkg::OP_WRAP;
                if (st.wrap_ok)
                    state_next = S_CORDIC_INIT;
            end
            S_CORDIC_INIT:
            begin
                cmd.op     = asi_pkg::OP_CORDIC_INIT;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.op = asi_pkg::OP_CORDIC_STEP;
                if (st.cordic_last)
                    state_next = S_MUL_SIN;
            end
            S_MUL_SIN:
            begin
                cmd.op     = asi_pkg::OP_MUL_SIN;
                state_next = S_MUL_COS;
            end
            S_MUL_COS:
            begin
                cmd.op     = asi_pkg::OP_MUL_COS;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.op        = is_start_reg ? asi_pkg::OP_FIN_START
                                                 : asi_pkg::OP_FIN_STEP;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            is_start_reg <= 1'b0;
            rej_code_reg <= asi_pkg::STATUS_OK;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            is_start_reg <= is_start_next;
            rej_code_reg <= rej_code_next;
        end
    end

endmodule

// File: design/arc_segment_interpolator.sv
// ----------------------------------------------------------------------------
// arc_segment_interpolator: helical arc interpolator, top level
// A start transaction sets up a helix and its segment count; each step
// transaction returns the next segment endpoint and its duration.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command per transaction: tuser[0] is the opcode (start
//   or step), tdata the start geometry. Every command yields exactly one
//   transaction on m_*, whose tuser gives status and segment-valid and whose
//   tlast marks the final segment of an arc.
//   cfg_* writes the minimum segment length (index 0) or the segment
//   period (index 1); always ready; user must use it only while idle (not enforced).
// Timing:
//   A step runs the step sum, the angle wrap, the one-step-a-cycle CORDIC
//   and two multiplies. A start that is taken runs a multiply, a square
//   root and five 40-bit divisions, then loads its angle and goes on as a step.
//   Busy and no-arc rejects answer from idle, a short start after its root.
//   One command is in flight at a time; s_tready is high only when idle.
// Reset and stalls:
//   Reset clears the arc state and loads the register defaults. A result
//   waits in the output register while m_tready is low, and the next
//   command is accepted and worked on meanwhile up to its own result.
// ----------------------------------------------------------------------------
module arc_segment_interpolator #(
    parameter int COUNT_WIDTH  = 24,
    parameter int CORDIC_STEPS = 28
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_first, start_second, start_linear, start_angle, arc_radius,
    // angle_travel, axial_travel, duration_us, one zero pad bit
    input  logic [255:0] s_tdata,
    // opcode, plane_select
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // point_first, point_second, point_linear, seg_duration_us
    output logic [127:0] m_tdata,
    // status, segment_valid
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [30:0]  cfg_data
);

    asi_pkg::cmd_t  cmd;
    asi_pkg::stat_t st;

    assign cfg_ready = 1'b1;

    asi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_opcode (s_tuser[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    asi_dpath #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // An accepted command takes the block out of idle in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // The last segment ends the arc
    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !st.running)
        else $error("arc still running after its last segment");

    // Segments and last flags only come with an ok status
    a_seg_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2] || m_tlast) |-> m_tuser[1:0] == asi_pkg::STATUS_OK)
        else $error("segment result with a failing status");

    // The last flag only marks a real segment
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[2])
        else $error("last flag without a segment");

endmodule
